@@ hw/rtl/tqe_pkg.sv @@
// Shared types and codes for the team queue engine.
`timescale 1ns / 1ps

package tqe_pkg;

    // Channel field widths
    localparam int KIND_W = 2;
    localparam int ELEM_W = 10;
    localparam int TEAM_W = 4;
    localparam int DEQ_W  = 10;
    localparam int STAT_W = 2;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_ASSIGN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEQUEUE = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic clearing;
        logic accept;
        logic enq_step;
        logic deq_step;
        logic data_step;
        logic result_load;
    } tqe_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic is_enq;
        logic deq_go;
        logic need_data;
    } tqe_stat_t;

endpackage

@@ hw/rtl/tqe_if.sv @@
// Valid/ready channel interfaces for request and result items.
`timescale 1ns / 1ps

interface tqe_in_if;
    logic                         valid;
    logic                         ready;
    logic [tqe_pkg::KIND_W-1:0]   kind;
    logic [tqe_pkg::ELEM_W-1:0]   element;
    logic [tqe_pkg::TEAM_W-1:0]   team;

    modport source (output valid, kind, element, team, input ready);
    modport sink   (input valid, kind, element, team, output ready);
endinterface

interface tqe_out_if;
    logic                         valid;
    logic                         ready;
    logic [tqe_pkg::DEQ_W-1:0]    dequeued;
    logic [tqe_pkg::STAT_W-1:0]   status;

    modport source (output valid, dequeued, status, input ready);
    modport sink   (input valid, dequeued, status, output ready);
endinterface

@@ hw/rtl/team_queue_engine_top.sv @@
// Team queue engine: request and result channels around controller and datapath.
// Assign, unused kind and dequeue on an empty ring finish at accept; enqueue
// after the membership read; a dequeue after the ring read, or for a team with
// data after the ring read, then the team store read. New items wait meanwhile.
// Reset: asynchronous, active low; the membership table is then swept clear, one
// entry a cycle over all 2^ELEMENT_BITS entries, before the first item is accepted.
`timescale 1ns / 1ps

module team_queue_engine_top
#(
    parameter int TEAMS        = 16,
    parameter int ELEMENT_BITS = 10,
    parameter int TEAM_DEPTH   = 64,
    parameter int ORDER_DEPTH  = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    tqe_in_if.sink      req,
    tqe_out_if.source   rsp
);

    tqe_pkg::tqe_cmd_t  cmd;
    tqe_pkg::tqe_stat_t stat;

    tqe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tqe_datapath
    #(
        .TEAMS        (TEAMS),
        .ELEMENT_BITS (ELEMENT_BITS),
        .TEAM_DEPTH   (TEAM_DEPTH),
        .ORDER_DEPTH  (ORDER_DEPTH)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_kind    (req.kind),
        .req_element (req.element),
        .req_team    (req.team),
        .dequeued    (rsp.dequeued),
        .status      (rsp.status)
    );

endmodule

@@ hw/rtl/tqe_ctrl.sv @@
// Sequencer for the team queue engine: clearing pass, item steps, handshakes.
`timescale 1ns / 1ps

module tqe_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  tqe_pkg::tqe_stat_t  stat,
    output tqe_pkg::tqe_cmd_t   cmd
);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_ENQ      = 3'd2;
    localparam logic [2:0] S_DEQ_RING = 3'd3;
    localparam logic [2:0] S_DEQ_DATA = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    // Take an item only when the result register is free or draining
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Step strobes
    always_comb
    begin
        cmd.clearing    = (state_reg == S_CLEAR);
        cmd.accept      = accept;
        cmd.enq_step    = (state_reg == S_ENQ);
        cmd.deq_step    = (state_reg == S_DEQ_RING);
        cmd.data_step   = (state_reg == S_DEQ_DATA);
        cmd.result_load = (accept && !stat.is_enq && !stat.deq_go)
                        || (state_reg == S_ENQ)
                        || ((state_reg == S_DEQ_RING) && !stat.need_data)
                        || (state_reg == S_DEQ_DATA);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && stat.is_enq)
                begin
                    state_next = S_ENQ;
                end
                else if (accept && stat.deq_go)
                begin
                    state_next = S_DEQ_RING;
                end
            end
            S_ENQ:
            begin
                state_next = S_IDLE;
            end
            S_DEQ_RING:
            begin
                state_next = stat.need_data ? S_DEQ_DATA : S_IDLE;
            end
            S_DEQ_DATA:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Result register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/tqe_datapath.sv @@
// Datapath: membership table, team FIFO store, order ring, pointers, result register.
`timescale 1ns / 1ps

module tqe_datapath
#(
    parameter int TEAMS        = 16,
    parameter int ELEMENT_BITS = 10,
    parameter int TEAM_DEPTH   = 64,
    parameter int ORDER_DEPTH  = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tqe_pkg::tqe_cmd_t             cmd,
    output tqe_pkg::tqe_stat_t            stat,
    input  logic [tqe_pkg::KIND_W-1:0]    req_kind,
    input  logic [tqe_pkg::ELEM_W-1:0]    req_element,
    input  logic [tqe_pkg::TEAM_W-1:0]    req_team,
    output logic [tqe_pkg::DEQ_W-1:0]     dequeued,
    output logic [tqe_pkg::STAT_W-1:0]    status
);

    localparam int ELEM_SPACE = 1 << ELEMENT_BITS;
    localparam int MW         = $clog2(TEAMS + 1);
    localparam int TIW        = (TEAMS > 1) ? $clog2(TEAMS) : 1;
    localparam int PW         = $clog2(TEAM_DEPTH);
    localparam int CW         = $clog2(TEAM_DEPTH + 1);
    localparam int RPW        = $clog2(ORDER_DEPTH);
    localparam int RCW        = $clog2(ORDER_DEPTH + 1);
    localparam int EW         = (ELEMENT_BITS > TIW) ? ELEMENT_BITS : TIW;
    localparam int RW         = EW + 1;
    localparam int SDEPTH     = TEAMS * TEAM_DEPTH;
    localparam int SAW        = $clog2(SDEPTH);

    // Memories
    logic [MW-1:0]           member_mem [ELEM_SPACE];
    logic [ELEMENT_BITS-1:0] store_mem  [SDEPTH];
    logic [RW-1:0]           ring_mem   [ORDER_DEPTH];

    // Registered read data and latched element
    logic [MW-1:0]           member_q;
    logic [ELEMENT_BITS-1:0] store_q;
    logic [RW-1:0]           ring_q;
    logic [ELEMENT_BITS-1:0] elem_reg;

    // Team FIFO pointers
    logic [PW-1:0]           head_reg  [TEAMS];
    logic [PW-1:0]           tail_reg  [TEAMS];
    logic [CW-1:0]           count_reg [TEAMS];

    // Order ring pointers
    logic [RPW-1:0]          order_head_reg;
    logic [RPW-1:0]          order_tail_reg;
    logic [RCW-1:0]          order_count_reg;

    logic [ELEMENT_BITS-1:0] clr_cnt_reg;

    logic [ELEMENT_BITS-1:0] elem_in;
    logic                    assign_wr;

    logic                    solo;
    logic [TIW-1:0]          t_enq;
    logic [CW-1:0]           cnt_enq;
    logic                    ring_full;
    logic                    team_full;
    logic                    team_idle;
    logic                    enq_ok_solo;
    logic                    enq_ok_team;
    logic                    ring_push;
    logic                    store_wr;
    logic [RW-1:0]           push_entry;

    logic                    solo_d;
    logic [TIW-1:0]          t_deq;
    logic [CW-1:0]           cnt_deq;
    logic                    team_pop;
    logic                    ring_pop;

    logic [tqe_pkg::DEQ_W-1:0]  res_deq;
    logic [tqe_pkg::STAT_W-1:0] res_st;
    logic [tqe_pkg::DEQ_W-1:0]  dequeued_reg;
    logic [tqe_pkg::STAT_W-1:0] status_reg;

    // Flat store address of a slot in a team's FIFO
    function automatic logic [SAW-1:0] store_addr(input logic [TIW-1:0] t,
                                                  input logic [PW-1:0]  p);
        return SAW'(32'(t) * TEAM_DEPTH + 32'(p));
    endfunction

    function automatic logic [PW-1:0] team_wrap(input logic [PW-1:0] p);
        return (p == PW'(TEAM_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [RPW-1:0] ring_wrap(input logic [RPW-1:0] p);
        return (p == RPW'(ORDER_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign elem_in   = ELEMENT_BITS'(req_element);
    assign assign_wr = cmd.accept && (req_kind == tqe_pkg::KIND_ASSIGN)
                     && (32'(req_team) < TEAMS);

    // Enqueue decisions
    always_comb
    begin
        solo        = (member_q == '0);
        t_enq       = TIW'(member_q - MW'(1));
        cnt_enq     = count_reg[t_enq];
        ring_full   = (order_count_reg == RCW'(ORDER_DEPTH));
        team_full   = (cnt_enq == CW'(TEAM_DEPTH));
        team_idle   = (cnt_enq == '0);
        enq_ok_solo = solo && !ring_full;
        enq_ok_team = !solo && !team_full && !(team_idle && ring_full);
        ring_push   = cmd.enq_step && (enq_ok_solo || (enq_ok_team && team_idle));
        store_wr    = cmd.enq_step && enq_ok_team;
        push_entry  = solo ? {1'b1, EW'(elem_reg)} : {1'b0, EW'(t_enq)};
    end

    // Dequeue decisions on the head ring entry
    always_comb
    begin
        solo_d   = ring_q[RW-1];
        t_deq    = ring_q[TIW-1:0];
        cnt_deq  = count_reg[t_deq];
        team_pop = cmd.deq_step && !solo_d && (cnt_deq != '0);
        ring_pop = cmd.deq_step
                 && (solo_d || (cnt_deq == '0) || (cnt_deq == CW'(1)));
    end

    // Status back to the controller
    always_comb
    begin
        stat.clear_done = (clr_cnt_reg == '1);
        stat.is_enq     = (req_kind == tqe_pkg::KIND_ENQUEUE);
        stat.deq_go     = (req_kind == tqe_pkg::KIND_DEQUEUE) && (order_count_reg != '0);
        stat.need_data  = !solo_d && (cnt_deq != '0);
    end

    // Membership table: clearing pass, assign writes, lookup at accept
    always_ff @(posedge clk)
    begin
        if (cmd.clearing)
        begin
            member_mem[clr_cnt_reg] <= '0;
        end
        else if (assign_wr)
        begin
            member_mem[elem_in] <= MW'(req_team) + MW'(1);
        end
        if (cmd.accept)
        begin
            member_q <= member_mem[elem_in];
            elem_reg <= elem_in;
        end
    end

    // Team FIFO store
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            store_mem[store_addr(t_enq, tail_reg[t_enq])] <= elem_reg;
        end
        if (team_pop)
        begin
            store_q <= store_mem[store_addr(t_deq, head_reg[t_deq])];
        end
    end

    // Order ring
    always_ff @(posedge clk)
    begin
        if (ring_push)
        begin
            ring_mem[order_tail_reg] <= push_entry;
        end
        if (cmd.accept)
        begin
            ring_q <= ring_mem[order_head_reg];
        end
    end

    // Pointers, counts and clearing counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TEAMS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            order_head_reg  <= '0;
            order_tail_reg  <= '0;
            order_count_reg <= '0;
            clr_cnt_reg     <= '0;
        end
        else
        begin
            if (cmd.clearing && (clr_cnt_reg != '1))
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (store_wr)
            begin
                tail_reg[t_enq]  <= team_wrap(tail_reg[t_enq]);
                count_reg[t_enq] <= cnt_enq + 1'b1;
            end
            if (team_pop)
            begin
                head_reg[t_deq]  <= team_wrap(head_reg[t_deq]);
                count_reg[t_deq] <= cnt_deq - 1'b1;
            end
            if (ring_push)
            begin
                order_tail_reg  <= ring_wrap(order_tail_reg);
                order_count_reg <= order_count_reg + 1'b1;
            end
            if (ring_pop)
            begin
                order_head_reg  <= ring_wrap(order_head_reg);
                order_count_reg <= order_count_reg - 1'b1;
            end
        end
    end

    // Result of the finishing step
    always_comb
    begin
        res_deq = '0;
        res_st  = tqe_pkg::ST_OK;
        priority if (cmd.accept)
        begin
            res_st = (req_kind == tqe_pkg::KIND_DEQUEUE) ? tqe_pkg::ST_EMPTY
                                                          : tqe_pkg::ST_OK;
        end
        else if (cmd.enq_step)
        begin
            res_st = (enq_ok_solo || enq_ok_team) ? tqe_pkg::ST_OK : tqe_pkg::ST_FULL;
        end
        else if (cmd.deq_step)
        begin
            if (solo_d)
            begin
                res_deq = tqe_pkg::DEQ_W'(ring_q[ELEMENT_BITS-1:0]);
            end
            else
            begin
                res_st = tqe_pkg::ST_EMPTY;
            end
        end
        else if (cmd.data_step)
        begin
            res_deq = tqe_pkg::DEQ_W'(store_q);
        end
        else
        begin
            res_deq = '0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            dequeued_reg <= res_deq;
            status_reg   <= res_st;
        end
    end

    assign dequeued = dequeued_reg;
    assign status   = status_reg;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the team queue engine: driver, monitor and item predictor.
`timescale 1ns / 1ps

module testbench;
    import tqe_pkg::*;

    // Block configuration under test
    localparam int TEAMS          = 16;
    localparam int ELEMENT_BITS   = 10;
    localparam int TEAM_DEPTH     = 64;
    localparam int ORDER_DEPTH    = 64;
    localparam int ELEM_SPACE     = 1 << ELEMENT_BITS;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam int ITEM_TARGET    = 1800;
    localparam int CALM_ITEMS     = 250;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PRINT_CAP      = 100;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ELEM_W-1:0] element;
        logic [TEAM_W-1:0] team;
    } request_t;

    typedef struct packed {
        logic [DEQ_W-1:0]  dequeued;
        logic [STAT_W-1:0] status;
    } result_t;

    // One slot of the order ring: a whole team, or a lone element
    typedef struct packed {
        logic              solo;
        logic [ELEM_W-1:0] id;
    } ring_entry_t;

    logic clk;
    logic rst_n;

    tqe_in_if  req_if ();
    tqe_out_if rsp_if ();

    team_queue_engine_top #(
        .TEAMS        (TEAMS),
        .ELEMENT_BITS (ELEMENT_BITS),
        .TEAM_DEPTH   (TEAM_DEPTH),
        .ORDER_DEPTH  (ORDER_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Predictor state
    logic [4:0]        member     [ELEM_SPACE];
    logic [ELEM_W-1:0] team_slots [TEAMS][TEAM_DEPTH];
    logic [5:0]        team_rd    [TEAMS];
    logic [5:0]        team_wr    [TEAMS];
    logic [6:0]        team_fill  [TEAMS];
    ring_entry_t       ring       [ORDER_DEPTH];
    logic [5:0]        ring_rd;
    logic [5:0]        ring_wr;
    logic [6:0]        ring_fill;

    // Traffic bookkeeping
    request_t pending_items [$];
    result_t  results_due   [$];
    int       plan_team     [ELEM_SPACE];
    int       recent_assigned [$];
    int       pushed_cnt;
    int       accepted_cnt;
    int       mismatch_cnt;
    int       quiet_cycles;
    int       send_gap;
    int       stall_left;
    logic     in_took;
    logic     calm;

    assign calm = (accepted_cnt >= ITEM_TARGET - CALM_ITEMS);

    function automatic logic [5:0] next_slot(input logic [5:0] p, input int depth);
        return (p == depth - 1) ? 6'd0 : p + 6'd1;
    endfunction

    // Ring push for enqueue and ring pop for dequeue
    task automatic ring_push(input ring_entry_t e);
        ring[ring_wr] = e;
        ring_wr       = next_slot(ring_wr, ORDER_DEPTH);
        ring_fill     = ring_fill + 7'd1;
    endtask

    task automatic ring_pop();
        ring_rd   = next_slot(ring_rd, ORDER_DEPTH);
        ring_fill = ring_fill - 7'd1;
    endtask

    // Work out the result of one accepted item and update the queue state
    task automatic serve_request(input request_t rq, output result_t res);
        logic [4:0]  m;
        logic [3:0]  t;
        ring_entry_t e;
        res.dequeued = '0;
        res.status   = ST_OK;
        case (rq.kind)
            KIND_ASSIGN:
            begin
                member[rq.element] = {1'b0, rq.team} + 5'd1;
            end
            KIND_ENQUEUE:
            begin
                m = member[rq.element];
                if (m == 5'd0)
                begin
                    // no team: the element takes a ring slot of its own
                    if (ring_fill >= ORDER_DEPTH)
                        res.status = ST_FULL;
                    else
                        ring_push('{solo: 1'b1, id: rq.element});
                end
                else
                begin
                    t = m[3:0] - 4'd1;
                    if (team_fill[t] >= TEAM_DEPTH)
                        res.status = ST_FULL;
                    else if (team_fill[t] == 7'd0 && ring_fill >= ORDER_DEPTH)
                        res.status = ST_FULL;
                    else
                    begin
                        // an empty team joins the ring tail
                        if (team_fill[t] == 7'd0)
                            ring_push('{solo: 1'b0, id: {{(ELEM_W-4){1'b0}}, t}});
                        team_slots[t][team_wr[t]] = rq.element;
                        team_wr[t]   = next_slot(team_wr[t], TEAM_DEPTH);
                        team_fill[t] = team_fill[t] + 7'd1;
                    end
                end
            end
            KIND_DEQUEUE:
            begin
                if (ring_fill == 7'd0)
                    res.status = ST_EMPTY;
                else
                begin
                    e = ring[ring_rd];
                    if (e.solo)
                    begin
                        res.dequeued = e.id;
                        ring_pop();
                    end
                    else
                    begin
                        t = e.id[3:0];
                        if (team_fill[t] == 7'd0)
                        begin
                            ring_pop();
                            res.status = ST_EMPTY;
                        end
                        else
                        begin
                            res.dequeued = team_slots[t][team_rd[t]];
                            team_rd[t]   = next_slot(team_rd[t], TEAM_DEPTH);
                            team_fill[t] = team_fill[t] - 7'd1;
                            // team leaves the ring once drained
                            if (team_fill[t] == 7'd0)
                                ring_pop();
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_cnt < PRINT_CAP)
            $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_cnt++;
    endtask

    // Queue one request for the driver; track team membership as planned
    task automatic send(input logic [KIND_W-1:0] kind, input int elem, input int team);
        request_t it;
        it.kind    = kind;
        it.element = elem[ELEM_W-1:0];
        it.team    = team[TEAM_W-1:0];
        pending_items.push_back(it);
        pushed_cnt++;
        if (kind == KIND_ASSIGN)
        begin
            plan_team[elem] = team;
            recent_assigned.push_back(elem);
            if (recent_assigned.size() > 64)
                void'(recent_assigned.pop_front());
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Request driver: changes on the falling edge, idles in bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_if.valid && !in_took)
            begin
                // current item still waiting for ready
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                req_if.valid <= 1'b0;
            end
            else if (pending_items.size() == 0)
                req_if.valid <= 1'b0;
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(0, 15);
                req_if.valid <= 1'b0;
            end
            else
            begin
                req_if.valid   <= 1'b1;
                req_if.kind    <= pending_items[0].kind;
                req_if.element <= pending_items[0].element;
                req_if.team    <= pending_items[0].team;
                void'(pending_items.pop_front());
            end
        end
    end

    // Result back-pressure in bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 15);
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // Monitor: predict on each accepted request, check each accepted result
    always @(posedge clk)
    begin : monitor_blk
        result_t  want;
        request_t rq;
        logic     out_took;
        if (rst_n)
        begin
            in_took  = req_if.valid && req_if.ready;
            out_took = rsp_if.valid && rsp_if.ready;
            if (in_took)
            begin
                rq.kind    = req_if.kind;
                rq.element = req_if.element;
                rq.team    = req_if.team;
                serve_request(rq, want);
                results_due.push_back(want);
                accepted_cnt++;
            end
            if (out_took)
            begin
                if (results_due.size() == 0)
                    report_mismatch($sformatf("result with nothing due: dequeued %0d status %0d",
                                              rsp_if.dequeued, rsp_if.status));
                else
                begin
                    want = results_due.pop_front();
                    if (rsp_if.dequeued !== want.dequeued)
                        report_mismatch($sformatf("dequeued %0d, predicted %0d",
                                                  rsp_if.dequeued, want.dequeued));
                    if (rsp_if.status !== want.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  rsp_if.status, want.status));
                end
            end
            // watchdog on cycles where nothing moves
            if (in_took || out_took)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus_blk
        int phase;
        int len;
        int t;
        int e;
        int picks [3];

        req_if.valid   = 1'b0;
        req_if.kind    = KIND_ASSIGN;
        req_if.element = '0;
        req_if.team    = '0;
        rsp_if.ready   = 1'b0;
        rst_n          = 1'b0;
        in_took        = 1'b0;
        pushed_cnt     = 0;
        accepted_cnt   = 0;
        mismatch_cnt   = 0;
        quiet_cycles   = 0;
        send_gap       = 0;
        stall_left     = 0;

        // predictor reset state
        for (int i = 0; i < ELEM_SPACE; i++)
        begin
            member[i]    = 5'd0;
            plan_team[i] = -1;
        end
        for (int i = 0; i < TEAMS; i++)
        begin
            team_rd[i]   = '0;
            team_wr[i]   = '0;
            team_fill[i] = '0;
        end
        ring_rd   = '0;
        ring_wr   = '0;
        ring_fill = '0;

        // Directed: empty dequeue, spare kind, solo entries, reassignment,
        // team leaving and rejoining at the tail
        send(KIND_DEQUEUE, 0, 0);
        send(KIND_SPARE, 1023, 15);
        send(KIND_ENQUEUE, 0, 0);
        send(KIND_ENQUEUE, 1023, 0);
        send(KIND_ASSIGN, 5, 0);
        send(KIND_ASSIGN, 1023, 15);
        send(KIND_ASSIGN, 6, 0);
        send(KIND_ASSIGN, 512, 15);
        send(KIND_ENQUEUE, 5, 0);
        send(KIND_ENQUEUE, 1023, 0);
        send(KIND_ENQUEUE, 6, 0);
        send(KIND_ENQUEUE, 512, 0);
        send(KIND_ASSIGN, 5, 15);
        send(KIND_ENQUEUE, 5, 0);
        repeat (7) send(KIND_DEQUEUE, 0, 0);
        send(KIND_ENQUEUE, 6, 0);
        send(KIND_DEQUEUE, 0, 0);
        send(KIND_DEQUEUE, 1023, 15);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // hold the sender until the directed part has fully drained
        while (!(accepted_cnt == pushed_cnt && results_due.size() == 0))
            @(negedge clk);

        // Random: mixed traffic, team floods, solo floods and drains
        while (pushed_cnt < ITEM_TARGET)
        begin
            phase = $urandom_range(0, 9);
            if (phase == 7)
            begin
                // flood one team with enqueues, at times past its depth
                t = $urandom_range(0, TEAMS - 1);
                for (int i = 0; i < 3; i++)
                begin
                    picks[i] = $urandom_range(0, ELEM_SPACE - 1);
                    send(KIND_ASSIGN, picks[i], t);
                end
                len = $urandom_range(50, 72);
                repeat (len) send(KIND_ENQUEUE, picks[$urandom_range(0, 2)], 0);
            end
            else if (phase == 8)
            begin
                // lone elements, at times enough to overflow the ring
                len = $urandom_range(40, 72);
                repeat (len)
                begin
                    e = $urandom_range(0, ELEM_SPACE - 1);
                    for (int k = 0; k < 8 && plan_team[e] >= 0; k++)
                        e = $urandom_range(0, ELEM_SPACE - 1);
                    send(KIND_ENQUEUE, e, $urandom_range(0, 15));
                end
            end
            else if (phase == 5 || phase == 6)
            begin
                len = $urandom_range(20, 80);
                repeat (len) send(KIND_DEQUEUE, $urandom_range(0, ELEM_SPACE - 1),
                                  $urandom_range(0, 15));
            end
            else
            begin
                len = $urandom_range(30, 60);
                repeat (len)
                begin
                    e = $urandom_range(0, ELEM_SPACE - 1);
                    if (recent_assigned.size() > 0 && $urandom_range(0, 1) == 0)
                        e = recent_assigned[$urandom_range(0, recent_assigned.size() - 1)];
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3:
                            send(KIND_ASSIGN, $urandom_range(0, ELEM_SPACE - 1),
                                 $urandom_range(0, TEAMS - 1));
                        4, 5, 6, 7, 8, 9, 10, 11, 12:
                            send(KIND_ENQUEUE, e, $urandom_range(0, 15));
                        19:
                            send(KIND_SPARE, e, $urandom_range(0, 15));
                        default:
                            send(KIND_DEQUEUE, e, $urandom_range(0, 15));
                    endcase
                end
            end
        end

        // wait for every result, then keep watching for stray ones
        while (!(accepted_cnt == pushed_cnt && results_due.size() == 0))
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_cnt == 0 && results_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
